@@ rtl/gtes_pkg.sv @@
package gtes_pkg;

  localparam int MAX_NODES_DEF = 256;
  localparam logic [8:0] NODE_COUNT_RESET = 9'd256;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_OFFER  = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  node_from;
    logic [7:0]  node_to;
    logic [31:0] edge_weight;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic        path_complete;
    logic [47:0] total_length;
    logic        length_saturated;
    logic [7:0]  end_first;
    logic [7:0]  end_second;
    logic        ends_valid;
  } out_t;

endpackage

@@ rtl/gtes_ram.sv @@
module gtes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/greedy_tour_edge_selector_top.sv @@
// Greedy-edge tour builder. A request is taken when start is high and busy is low; busy falls
// in the cycle in which its result is shown. Every request gives exactly one result, presented
// on result for a single cycle with done high, and the receiver cannot stall it. A start request
// clears both memories before its result is shown, clearing one memory entry a cycle, and the
// clearing pass after reset holds busy while it runs. An accepted edge offer reads both endpoint
// degrees, walks the parent links in the two set root searches and then writes the join; union
// by size keeps each chain at most log2 of MAX_NODES links long. Rejected offers finish sooner;
// when the path is complete or an endpoint is out of range, done rises in the cycle after the
// offer is taken. A finish request sweeps the first n entries of the degree memory, where n is
// node_count clamped to 2..MAX_NODES. Node state lives in two simple dual-port RAMs.
module greedy_tour_edge_selector_top #(
  parameter int MAX_NODES = gtes_pkg::MAX_NODES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  gtes_pkg::in_t  request,
  input  logic           cfg_we,
  input  logic [8:0]     cfg_data,
  output logic           done,
  output gtes_pkg::out_t result
);
  import gtes_pkg::*;

  localparam int NW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int SW = $clog2(MAX_NODES + 1);
  localparam int UW = NW + SW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_DEGU   = 4'd2;
  localparam logic [3:0] S_DEGV   = 4'd3;
  localparam logic [3:0] S_DEGCHK = 4'd4;
  localparam logic [3:0] S_FRD    = 4'd5;
  localparam logic [3:0] S_FCHK   = 4'd6;
  localparam logic [3:0] S_JOIN1  = 4'd7;
  localparam logic [3:0] S_JOIN2  = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0]    state;
  logic [8:0]    node_count;
  logic [SW-1:0] n_act;
  logic [SW-1:0] cnt;
  logic          clr_emit;
  logic          pend;
  logic [NW-1:0] pidx;
  logic          have_a;
  logic          have_b;
  logic [NW-1:0] end_a;
  logic [NW-1:0] end_b;
  logic [NW-1:0] u_addr;
  logic [NW-1:0] v_addr;
  logic [31:0]   weight;
  logic [1:0]    du;
  logic [1:0]    dv;
  logic [NW-1:0] cur;
  logic          which;
  logic [NW-1:0] ru;
  logic [NW-1:0] rv;
  logic [SW-1:0] su;
  logic [SW-1:0] sv;
  logic [SW-1:0] edges_taken;
  logic [47:0]   length_sum;
  logic          sum_saturated;
  logic          tour_done;

  logic          uf_we;
  logic [NW-1:0] uf_waddr;
  logic [UW-1:0] uf_wdata;
  logic [UW-1:0] uf_rdata;
  logic          dg_we;
  logic [NW-1:0] dg_waddr;
  logic [1:0]    dg_wdata;
  logic [NW-1:0] dg_raddr;
  logic [1:0]    dg_rdata;

  logic [NW-1:0] rd_parent;
  logic [SW-1:0] rd_size;
  logic          swap;
  logic [NW-1:0] root_a;
  logic [NW-1:0] root_b;
  logic [48:0]   sum_wide;
  logic [SW-1:0] edges_new;
  logic          limit_hit;
  logic          limit_new;

  assign busy      = (state != S_IDLE);
  assign rd_parent = uf_rdata[UW-1:SW];
  assign rd_size   = uf_rdata[SW-1:0];
  assign swap      = (su < sv);
  assign root_a    = swap ? rv : ru;
  assign root_b    = swap ? ru : rv;
  assign sum_wide  = {1'b0, length_sum} + {17'd0, weight};
  assign edges_new = edges_taken + SW'(1);
  assign limit_hit = (32'(edges_taken) + 32'd1 >= 32'(n_act));
  assign limit_new = (32'(edges_new) + 32'd1 >= 32'(n_act));

  always_comb begin
    if ({23'd0, node_count} < 32'd2) begin
      n_act = SW'(2);
    end else if ({23'd0, node_count} > 32'(MAX_NODES)) begin
      n_act = SW'(MAX_NODES);
    end else begin
      n_act = SW'(node_count);
    end
  end

  always_comb begin
    uf_we    = 1'b0;
    uf_waddr = cnt[NW-1:0];
    uf_wdata = {cnt[NW-1:0], SW'(1)};
    dg_we    = 1'b0;
    dg_waddr = cnt[NW-1:0];
    dg_wdata = 2'd0;
    dg_raddr = cnt[NW-1:0];
    case (state)
      S_CLR: begin
        uf_we = 1'b1;
        dg_we = 1'b1;
      end
      S_DEGU: begin
        dg_raddr = u_addr;
      end
      S_DEGV: begin
        dg_raddr = v_addr;
      end
      S_JOIN1: begin
        uf_we    = 1'b1;
        uf_waddr = root_b;
        uf_wdata = {root_a, swap ? su : sv};
        dg_we    = 1'b1;
        dg_waddr = u_addr;
        dg_wdata = du + 2'd1;
      end
      S_JOIN2: begin
        uf_we    = 1'b1;
        uf_waddr = root_a;
        uf_wdata = {root_a, SW'(su + sv)};
        dg_we    = 1'b1;
        dg_waddr = v_addr;
        dg_wdata = dv + 2'd1;
      end
      default: begin
      end
    endcase
  end

  gtes_ram #(.WIDTH(UW), .DEPTH(MAX_NODES)) u_uf_ram (
    .clk   (clk),
    .we    (uf_we),
    .waddr (uf_waddr),
    .wdata (uf_wdata),
    .raddr (cur),
    .rdata (uf_rdata)
  );

  gtes_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk   (clk),
    .we    (dg_we),
    .waddr (dg_waddr),
    .wdata (dg_wdata),
    .raddr (dg_raddr),
    .rdata (dg_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      node_count    <= NODE_COUNT_RESET;
      cnt           <= '0;
      clr_emit      <= 1'b0;
      pend          <= 1'b0;
      done          <= 1'b0;
      edges_taken   <= '0;
      length_sum    <= '0;
      sum_saturated <= 1'b0;
      tour_done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            u_addr <= NW'(request.node_from);
            v_addr <= NW'(request.node_to);
            weight <= request.edge_weight;
            cnt    <= '0;
            result <= '{accepted: 1'b0,
                        path_complete: tour_done ||
                                       ((request.opcode == OP_OFFER) && limit_hit),
                        total_length: length_sum,
                        length_saturated: sum_saturated,
                        end_first: 8'd0,
                        end_second: 8'd0,
                        ends_valid: 1'b0};
            case (request.opcode)
              OP_START: begin
                clr_emit <= 1'b1;
                state    <= S_CLR;
              end
              OP_OFFER: begin
                if (tour_done || limit_hit) begin
                  tour_done <= 1'b1;
                  done      <= 1'b1;
                end else if ((32'(request.node_from) < 32'(n_act)) &&
                             (32'(request.node_to) < 32'(n_act))) begin
                  state <= S_DEGU;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_FINISH: begin
                pend   <= 1'b0;
                have_a <= 1'b0;
                have_b <= 1'b0;
                state  <= S_FIN;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_CLR: begin
          cnt <= cnt + SW'(1);
          if (32'(cnt) == 32'(MAX_NODES - 1)) begin
            edges_taken   <= '0;
            length_sum    <= '0;
            sum_saturated <= 1'b0;
            tour_done     <= 1'b0;
            result        <= '0;
            done          <= clr_emit;
            clr_emit      <= 1'b0;
            state         <= S_IDLE;
          end
        end
        S_DEGU: begin
          state <= S_DEGV;
        end
        S_DEGV: begin
          du    <= dg_rdata;
          state <= S_DEGCHK;
        end
        S_DEGCHK: begin
          dv    <= dg_rdata;
          cur   <= u_addr;
          which <= 1'b0;
          if (du >= 2'd2 || dg_rdata >= 2'd2) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_FRD;
          end
        end
        S_FRD: begin
          state <= S_FCHK;
        end
        S_FCHK: begin
          if (rd_parent != cur) begin
            cur   <= rd_parent;
            state <= S_FRD;
          end else if (!which) begin
            ru    <= cur;
            su    <= rd_size;
            cur   <= v_addr;
            which <= 1'b1;
            state <= S_FRD;
          end else begin
            rv <= cur;
            sv <= rd_size;
            if (ru == cur) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_JOIN1;
            end
          end
        end
        S_JOIN1: begin
          state <= S_JOIN2;
        end
        S_JOIN2: begin
          edges_taken <= edges_new;
          if (sum_wide[48]) begin
            length_sum    <= '1;
            sum_saturated <= 1'b1;
          end else begin
            length_sum <= sum_wide[47:0];
          end
          result <= '{accepted: 1'b1,
                      path_complete: limit_new,
                      total_length: sum_wide[48] ? {48{1'b1}} : sum_wide[47:0],
                      length_saturated: sum_saturated || sum_wide[48],
                      end_first: 8'd0,
                      end_second: 8'd0,
                      ends_valid: 1'b0};
          if (limit_new) begin
            tour_done <= 1'b1;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_FIN: begin
          if (cnt < n_act) begin
            pend <= 1'b1;
            pidx <= cnt[NW-1:0];
            cnt  <= cnt + SW'(1);
          end else begin
            pend <= 1'b0;
          end
          if (pend && dg_rdata == 2'd1) begin
            if (!have_a) begin
              have_a <= 1'b1;
              end_a  <= pidx;
            end else begin
              have_b <= 1'b1;
              end_b  <= pidx;
            end
          end
          if (!pend && cnt >= n_act) begin
            result <= '{accepted: 1'b0,
                        path_complete: tour_done,
                        total_length: length_sum,
                        length_saturated: sum_saturated,
                        end_first: (have_a && have_b) ? 8'(end_a) : 8'd0,
                        end_second: (have_a && have_b) ? 8'(end_b) : 8'd0,
                        ends_valid: have_a && have_b};
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result strobe without a request in progress");
  a_ends_order: assert property (@(posedge clk) disable iff (rst)
    done && result.ends_valid |-> result.end_first < result.end_second)
    else $error("tour ends out of order");
  a_accept_not_finish: assert property (@(posedge clk) disable iff (rst)
    done && result.accepted |-> !result.ends_valid)
    else $error("accepted edge reported with tour ends");

endmodule
